@@ sv/tlpt_pkg.sv @@
// Package for the two-level page table engine: payload structs, codes, states,
// the controller/datapath command and status structs, and the index reduction.
// No dependencies.
package tlpt_pkg;

  localparam int unsigned DIR_ENTRIES_DEF = 1024;
  localparam int unsigned TBL_ENTRIES_DEF = 1024;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam logic CFG_ENTRY_FLAG_MASK = 1'b0;
  localparam logic [11:0] FLAG_MASK_RESET = 12'hFFF;

  localparam int unsigned OFFSET_BITS = 12;
  localparam int unsigned VA_DIR_LSB = 22;

  typedef enum logic [1:0] {
    OP_MAP       = 2'd0,
    OP_UNMAP     = 2'd1,
    OP_TRANSLATE = 2'd2,
    OP_OR_FLAGS  = 2'd3
  } tlpt_op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_NO_TABLE   = 3'd2,
    ST_ALREADY    = 3'd3,
    ST_NOT_MAPPED = 3'd4,
    ST_NO_FRAME   = 3'd5
  } tlpt_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_DONE
  } tlpt_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic [11:0] entry_flags;
    logic [31:0] table_frame;
  } tlpt_in_t;

  typedef struct packed {
    tlpt_status_t status;
    logic [31:0]  result_address;
    logic         flush_one_page;
    logic         flush_everything;
  } tlpt_out_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic eval;
    logic sweep_dir;
    logic sweep_tbl;
    logic out_load;
  } tlpt_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic need_zero;
    logic out_free;
  } tlpt_sts_t;

  // Reduces a 10-bit index modulo m (16 <= m <= 1024) by restoring
  // compare-and-subtract; the quotient never exceeds 63.
  function automatic logic [9:0] idx_mod(logic [9:0] v, int unsigned m);
    logic [16:0] acc;
    logic [16:0] sub;
    acc = {7'b0, v};
    for (int k = 6; k >= 0; k--) begin
      sub = 17'(m) << k;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[9:0];
  endfunction

endpackage

@@ sv/tlpt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/tlpt_ctrl.sv @@
// Controller state machine of the page table engine: sequences the clear pass,
// accept, memory read, evaluation, table zeroing and result hand-off. Uses tlpt_pkg.
module tlpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output tlpt_pkg::tlpt_cmd_t cmd,
  input  tlpt_pkg::tlpt_sts_t sts
);
  import tlpt_pkg::*;

  tlpt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep_dir = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_zero ? S_ZERO : S_DONE;
      end
      S_ZERO: begin
        cmd.sweep_tbl = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_READ)
    else $error("accepted item did not move to the read step");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_zero_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO && sts.sweep_done) |=> state_r == S_DONE)
    else $error("table zeroing did not finish into the result step");
`endif

endmodule

@@ sv/tlpt_datapath.sv @@
// Datapath of the page table engine: request registers, index reduction,
// directory and table RAMs, entry evaluation, sweep counter and output register.
// Uses tlpt_pkg and tlpt_ram.
module tlpt_datapath #(
  parameter int unsigned DIRECTORY_ENTRIES = tlpt_pkg::DIR_ENTRIES_DEF,
  parameter int unsigned TABLE_ENTRIES     = tlpt_pkg::TBL_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlpt_pkg::tlpt_in_t  in_data,
  input  logic [11:0]         flag_mask,
  input  tlpt_pkg::tlpt_cmd_t cmd,
  output tlpt_pkg::tlpt_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output tlpt_pkg::tlpt_out_t out_data
);
  import tlpt_pkg::*;

  localparam int unsigned DIW = $clog2(DIRECTORY_ENTRIES);
  localparam int unsigned TIW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW  = (DIW > TIW) ? DIW : TIW;
  localparam int unsigned TBL_DEPTH = 1 << (DIW + TIW);
  localparam logic [CW-1:0] DIR_LAST = CW'(DIRECTORY_ENTRIES - 1);
  localparam logic [CW-1:0] TBL_LAST = CW'(TABLE_ENTRIES - 1);

  tlpt_in_t         req_r;
  logic [DIW-1:0]   d_idx_r;
  logic [TIW-1:0]   t_idx_r;
  logic [9:0]       d_mod, t_mod;
  logic [CW-1:0]    ctr_r, ctr_nxt;
  tlpt_out_t        res_r;
  tlpt_out_t        out_data_r;
  logic             out_valid_r, out_valid_nxt;

  logic [31:0]      dir_q, ent_q;
  logic             dir_we, tbl_we;
  logic [DIW-1:0]   dir_waddr;
  logic [DIW+TIW-1:0] tbl_waddr;
  logic [31:0]      dir_wd, tbl_wd;

  // Evaluation results.
  tlpt_status_t     ev_status;
  logic [31:0]      ev_addr;
  logic             ev_one, ev_all, ev_zero;
  logic             ev_dir_we, ev_tbl_we;
  logic [31:0]      ev_dir_wd, ev_tbl_wd;
  logic             mis, dir_p, ent_p;
  logic [31:0]      need_map, need_or, page_entry;

  assign d_mod = idx_mod(in_data.virtual_address[31:22], DIRECTORY_ENTRIES);
  assign t_mod = idx_mod(in_data.virtual_address[21:12], TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_data;
      d_idx_r <= d_mod[DIW-1:0];
      t_idx_r <= t_mod[TIW-1:0];
    end
    if (cmd.eval) begin
      res_r.status           <= ev_status;
      res_r.result_address   <= ev_addr;
      res_r.flush_one_page   <= ev_one;
      res_r.flush_everything <= ev_all;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  always_comb begin
    ctr_nxt = '0;
    if (cmd.sweep_dir || cmd.sweep_tbl) begin
      ctr_nxt = ctr_r + CW'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.sweep_done = cmd.sweep_dir ? (ctr_r == DIR_LAST) : (ctr_r == TBL_LAST);
  assign sts.need_zero  = ev_zero;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Entry evaluation against the directory and table words read for this item.
  assign dir_p      = dir_q[0];
  assign ent_p      = ent_q[0];
  assign need_map   = {29'b0, req_r.entry_flags[2], 2'b11};
  assign need_or    = need_map;
  assign page_entry = {req_r.physical_address[31:12],
                       req_r.entry_flags & flag_mask} | 32'h1;
  assign mis = (req_r.virtual_address[11:0] != 12'b0) ||
               (tlpt_op_t'(req_r.operation) == OP_MAP &&
                req_r.physical_address[11:0] != 12'b0);

  always_comb begin
    ev_status = ST_OK;
    ev_addr   = '0;
    ev_one    = 1'b0;
    ev_all    = 1'b0;
    ev_zero   = 1'b0;
    ev_dir_we = 1'b0;
    ev_dir_wd = dir_q;
    ev_tbl_we = 1'b0;
    ev_tbl_wd = ent_q;
    unique case (tlpt_op_t'(req_r.operation))
      OP_MAP: begin
        if (mis) begin
          ev_status = ST_MISALIGNED;
        end else if (!dir_p) begin
          if (req_r.table_frame == 32'b0) begin
            ev_status = ST_NO_FRAME;
          end else begin
            // New table: the page entry goes in during the zeroing sweep.
            ev_dir_we = 1'b1;
            ev_dir_wd = {req_r.table_frame[31:12], 12'b0} | need_map;
            ev_all    = 1'b1;
            ev_one    = 1'b1;
            ev_zero   = 1'b1;
          end
        end else begin
          if ((dir_q & need_map) != need_map) begin
            ev_dir_we = 1'b1;
            ev_dir_wd = dir_q | need_map;
            ev_all    = 1'b1;
          end
          if (ent_p) begin
            ev_status = ST_ALREADY;
          end else begin
            ev_tbl_we = 1'b1;
            ev_tbl_wd = page_entry;
            ev_one    = 1'b1;
          end
        end
      end
      OP_UNMAP: begin
        if (mis) begin
          ev_status = ST_MISALIGNED;
        end else if (!dir_p) begin
          ev_status = ST_NO_TABLE;
        end else if (!ent_p) begin
          ev_status = ST_NOT_MAPPED;
        end else begin
          ev_tbl_we = 1'b1;
          ev_tbl_wd = '0;
          ev_one    = 1'b1;
          ev_addr   = {ent_q[31:12], 12'b0};
        end
      end
      OP_TRANSLATE: begin
        if (!dir_p) begin
          ev_status = ST_NO_TABLE;
        end else if (!ent_p) begin
          ev_status = ST_NOT_MAPPED;
        end else begin
          ev_addr = {ent_q[31:12], req_r.virtual_address[11:0]};
        end
      end
      OP_OR_FLAGS: begin
        if (mis) begin
          ev_status = ST_MISALIGNED;
        end else if (!dir_p) begin
          ev_status = ST_NO_TABLE;
        end else begin
          if ((dir_q & need_or) != need_or) begin
            ev_dir_we = 1'b1;
            ev_dir_wd = dir_q | need_or;
            ev_all    = 1'b1;
          end
          if (!ent_p) begin
            ev_status = ST_NOT_MAPPED;
          end else if ((ent_q | {29'b0, req_r.entry_flags[2:1], 1'b1}) != ent_q) begin
            ev_tbl_we = 1'b1;
            ev_tbl_wd = ent_q | {29'b0, req_r.entry_flags[2:1], 1'b1};
            ev_one    = 1'b1;
          end
        end
      end
      default: begin
        ev_status = ST_OK;
      end
    endcase
  end

  // Write port selection: sweeps own the ports while they run.
  always_comb begin
    if (cmd.sweep_dir) begin
      dir_we    = 1'b1;
      dir_waddr = ctr_r[DIW-1:0];
      dir_wd    = '0;
    end else begin
      dir_we    = cmd.eval && ev_dir_we;
      dir_waddr = d_idx_r;
      dir_wd    = ev_dir_wd;
    end
    if (cmd.sweep_tbl) begin
      tbl_we    = 1'b1;
      tbl_waddr = {d_idx_r, ctr_r[TIW-1:0]};
      tbl_wd    = (ctr_r[TIW-1:0] == t_idx_r) ? page_entry : 32'b0;
    end else begin
      tbl_we    = cmd.eval && ev_tbl_we;
      tbl_waddr = {d_idx_r, t_idx_r};
      tbl_wd    = ev_tbl_wd;
    end
  end

  tlpt_ram #(
    .WIDTH (32),
    .DEPTH (DIRECTORY_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wd),
    .re    (cmd.rd),
    .raddr (d_idx_r),
    .rdata (dir_q)
  );

  tlpt_ram #(
    .WIDTH (32),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wd),
    .re    (cmd.rd),
    .raddr ({d_idx_r, t_idx_r}),
    .rdata (ent_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_tbl_write_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && ev_tbl_we) |-> dir_q[0])
    else $error("page entry written under a directory entry that is not present");

  a_sweep_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_dir || cmd.sweep_tbl) |-> !cmd.rd)
    else $error("memory read issued during a sweep");
`endif

endmodule

@@ sv/two_level_page_table_engine_unit.sv @@
// Top level of the two-level page table engine: configuration register port,
// controller and datapath. Uses tlpt_pkg, tlpt_ctrl and tlpt_datapath.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   in_data   (tlpt_in_t)
//   out_      output     out_valid / out_ready out_data  (tlpt_out_t)
//   config    input      psel/penable/pwrite   paddr, pwdata -> prdata (entry_flag_mask)
//
// An ordinary item goes through accept, RAM read, evaluate and output hand-off; a map
// that creates a table adds a pass in which the table RAM zeroes it, one entry a cycle.
// After reset the directory RAM is cleared in a pass over its DIRECTORY_ENTRIES entries,
// during which no item is accepted; configuration writes are taken at any time.
// A finished result waits in the output register, and the next item is accepted
// and worked on meanwhile; it stalls only at its own hand-off.
module two_level_page_table_engine_unit #(
  parameter int unsigned DIRECTORY_ENTRIES = tlpt_pkg::DIR_ENTRIES_DEF,
  parameter int unsigned TABLE_ENTRIES     = tlpt_pkg::TBL_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tlpt_pkg::tlpt_in_t          in_data,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output tlpt_pkg::tlpt_out_t         out_data,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlpt_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tlpt_pkg::*;

  tlpt_cmd_t   cmd;
  tlpt_sts_t   sts;
  logic [11:0] flag_mask_r, flag_mask_nxt;
  logic        cfg_wr;

  // The only register sits at byte address zero; bit 2 of paddr selects the
  // register index and the two low bits are the byte offset.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    flag_mask_nxt = flag_mask_r;
    if (cfg_wr && paddr[2] == CFG_ENTRY_FLAG_MASK) begin
      flag_mask_nxt = pwdata[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_mask_r <= FLAG_MASK_RESET;
    end else begin
      flag_mask_r <= flag_mask_nxt;
    end
  end

  assign prdata = (paddr[2] == CFG_ENTRY_FLAG_MASK) ? {20'b0, flag_mask_r} : 32'b0;

  // The controller decides when each step happens; the datapath holds the
  // request, both memories and the result.
  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tlpt_datapath #(
    .DIRECTORY_ENTRIES (DIRECTORY_ENTRIES),
    .TABLE_ENTRIES     (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .flag_mask (flag_mask_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb_two_level_page_table_engine_unit.sv @@
// Self-checking testbench for two_level_page_table_engine_unit: map, unmap,
// translate and flag-upgrade requests checked against a behavioral page walker.
// Depends on tlpt_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_two_level_page_table_engine_unit;
  import tlpt_pkg::*;

  // The instance uses its default sizes; the walker below mirrors them.
  localparam int unsigned DIR_N = DIR_ENTRIES_DEF;
  localparam int unsigned TBL_N = TBL_ENTRIES_DEF;

  // Bits of directory and page entries, as the engine stores them.
  localparam logic [31:0] PTE_PRESENT  = 32'h0000_0001;
  localparam logic [31:0] PTE_WRITABLE = 32'h0000_0002;
  localparam logic [31:0] PTE_USER     = 32'h0000_0004;
  localparam logic [31:0] FRAME_MASK   = 32'hFFFF_F000;

  localparam int unsigned PHASES = 5;
  localparam int unsigned RANDOM_PER_PHASE = 95;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tlpt_in_t            in_data;
  logic                out_valid;
  logic                out_ready;
  tlpt_out_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  two_level_page_table_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the engine state: the directory is cleared at reset, while page
  // table entries only come into existence when a map creates their table.
  logic [31:0] dir_mirror [DIR_N];
  logic [31:0] page_mirror [int unsigned];
  logic [11:0] flag_mask;

  // Results that the engine still owes, oldest first.
  tlpt_out_t expected_results[$];

  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned sent_count;
  int unsigned tables_created;
  int unsigned op_count [4];
  int unsigned send_pace;
  int unsigned sink_pace;

  // Directory and table indexes that random requests mostly draw from. The
  // pools are small on purpose so that maps, unmaps and lookups collide often
  // and each new directory entry (a full table clear) stays rare.
  int unsigned dir_pool [6] = '{0, 1, 2, 511, 1022, 1023};
  int unsigned tbl_pool [8] = '{0, 1, 2, 3, 512, 1021, 1022, 1023};

  // One row of the directed table. Rows with typed_want set carry an
  // expectation written out by hand; the others are left to the walker.
  typedef struct {
    tlpt_in_t  req;
    bit        typed_want;
    tlpt_out_t want;
  } walk_case_t;

  walk_case_t directed_cases[$];

  always #1 clk = ~clk;

  // Generous ceiling: every request creating a table and both sides stalling
  // their longest would still finish well inside this.
  initial begin : watchdog
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic string show_result(tlpt_out_t r);
    return $sformatf("status %0d addr %08h flush_page %b flush_all %b",
                     r.status, r.result_address, r.flush_one_page, r.flush_everything);
  endfunction

  task automatic note_mismatch(string what, string want, string got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s mismatch", $realtime, what);
      $display("    expected: %s", want);
      $display("    actual:   %s", got);
    end
  endtask

  // Sets the needed permission bits in a directory entry; reports whether the
  // entry changed, which is what asks for a full TLB flush.
  function automatic bit widen_dir(int unsigned d, logic [31:0] need);
    if ((dir_mirror[d] & need) != need) begin
      dir_mirror[d] = dir_mirror[d] | need;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Walks the two-level table for one request, updates the mirror and returns
  // the result the engine must produce.
  function automatic tlpt_out_t predict_walk(tlpt_in_t req);
    tlpt_out_t   res;
    logic [31:0] va;
    logic [31:0] pa;
    logic [31:0] tf;
    logic [31:0] fl;
    logic [31:0] need;
    logic [31:0] pte;
    int unsigned d;
    int unsigned slot;
    res.status           = ST_OK;
    res.result_address   = '0;
    res.flush_one_page   = 1'b0;
    res.flush_everything = 1'b0;
    va   = req.virtual_address;
    pa   = req.physical_address;
    tf   = req.table_frame;
    fl   = {20'b0, req.entry_flags};
    d    = (va >> VA_DIR_LSB) % DIR_N;
    slot = d * TBL_N + ((va >> OFFSET_BITS) & 32'h3FF) % TBL_N;
    case (tlpt_op_t'(req.operation))
      OP_MAP: begin
        if (va[11:0] != 0 || pa[11:0] != 0) begin
          res.status = ST_MISALIGNED;
        end else if (!dir_mirror[d][0] && tf == 0) begin
          res.status = ST_NO_FRAME;
        end else begin
          need = PTE_PRESENT | PTE_WRITABLE | (fl & PTE_USER);
          if (!dir_mirror[d][0]) begin
            dir_mirror[d] = (tf & FRAME_MASK) | need;
            res.flush_everything = 1'b1;
            tables_created++;
            for (int i = 0; i < TBL_N; i++) page_mirror[d * TBL_N + i] = '0;
          end else begin
            res.flush_everything = widen_dir(d, need);
          end
          // A directory upgrade made above stays even when the page is taken.
          if (page_mirror[slot][0]) begin
            res.status = ST_ALREADY;
          end else begin
            page_mirror[slot] = (pa & FRAME_MASK) | (fl & {20'b0, flag_mask}) | PTE_PRESENT;
            res.flush_one_page = 1'b1;
          end
        end
      end
      OP_UNMAP: begin
        if (va[11:0] != 0) begin
          res.status = ST_MISALIGNED;
        end else if (!dir_mirror[d][0]) begin
          res.status = ST_NO_TABLE;
        end else begin
          pte = page_mirror[slot];
          if (!pte[0]) begin
            res.status = ST_NOT_MAPPED;
          end else begin
            page_mirror[slot] = '0;
            res.flush_one_page = 1'b1;
            res.result_address = pte & FRAME_MASK;
          end
        end
      end
      OP_TRANSLATE: begin
        // No alignment check here: the offset is carried into the result.
        if (!dir_mirror[d][0]) begin
          res.status = ST_NO_TABLE;
        end else begin
          pte = page_mirror[slot];
          if (!pte[0]) res.status = ST_NOT_MAPPED;
          else res.result_address = (pte & FRAME_MASK) | {20'b0, va[11:0]};
        end
      end
      default: begin
        if (va[11:0] != 0) begin
          res.status = ST_MISALIGNED;
        end else if (!dir_mirror[d][0]) begin
          res.status = ST_NO_TABLE;
        end else begin
          // Only the writable and user bits can be raised.
          fl = fl & (PTE_WRITABLE | PTE_USER);
          need = PTE_PRESENT | PTE_WRITABLE | (fl & PTE_USER);
          res.flush_everything = widen_dir(d, need);
          pte = page_mirror[slot];
          if (!pte[0]) begin
            res.status = ST_NOT_MAPPED;
          end else if ((pte | fl | PTE_PRESENT) != pte) begin
            page_mirror[slot] = pte | fl | PTE_PRESENT;
            res.flush_one_page = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  // Pause before an item or before taking a result: none at all, a pause of random
  // length, or mostly back to back with an occasional gap.
  function automatic int unsigned draw_pause(int unsigned pace);
    case (pace)
      0: return 0;
      1: return $urandom_range(16);
      default: return ($urandom_range(7) == 0) ? $urandom_range(16) : 0;
    endcase
  endfunction

  // Builds a random request. Addresses mostly fall on a few pooled slots so
  // that maps land on mapped pages and lookups find something; a share of
  // requests use any index, any offset and any frame.
  function automatic tlpt_in_t make_random_request();
    tlpt_in_t    req;
    logic [9:0]  dir_idx;
    logic [9:0]  tbl_idx;
    logic [11:0] offset;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) req.operation = OP_MAP;
    else if (pick < 55) req.operation = OP_UNMAP;
    else if (pick < 80) req.operation = OP_TRANSLATE;
    else req.operation = OP_OR_FLAGS;
    dir_idx = ($urandom_range(19) == 0) ? 10'($urandom_range(1023))
                                        : 10'(dir_pool[$urandom_range(5)]);
    tbl_idx = ($urandom_range(4) == 0) ? 10'($urandom_range(1023))
                                       : 10'(tbl_pool[$urandom_range(7)]);
    if (req.operation == OP_TRANSLATE) offset = 12'($urandom_range(4095));
    else if ($urandom_range(9) == 0) offset = 12'($urandom_range(4095, 1));
    else offset = '0;
    req.virtual_address = {dir_idx, tbl_idx, offset};
    req.physical_address = $urandom();
    if ($urandom_range(9) != 0) req.physical_address[11:0] = '0;
    req.entry_flags = 12'($urandom_range(4095));
    case ($urandom_range(9))
      0: req.table_frame = '0;
      1: req.table_frame = 32'hFFFF_FFFF;
      default: req.table_frame = $urandom();
    endcase
    return req;
  endfunction

  task automatic add_case(tlpt_op_t op, logic [31:0] va, logic [31:0] pa, logic [11:0] fl,
                          logic [31:0] tf, bit typed_want = 1'b0,
                          tlpt_status_t st = ST_OK, logic [31:0] addr = '0,
                          logic one = 1'b0, logic all = 1'b0);
    walk_case_t c;
    c.req.operation          = op;
    c.req.virtual_address    = va;
    c.req.physical_address   = pa;
    c.req.entry_flags        = fl;
    c.req.table_frame        = tf;
    c.typed_want             = typed_want;
    c.want.status            = st;
    c.want.result_address    = addr;
    c.want.flush_one_page    = one;
    c.want.flush_everything  = all;
    directed_cases.push_back(c);
  endtask

  // Presents one item and holds it until the engine takes it. The walker runs
  // at the accepting edge so that expectations queue up in acceptance order.
  task automatic send_request(tlpt_in_t req, bit typed_want, tlpt_out_t want);
    tlpt_out_t   predicted;
    int unsigned pause;
    if (sent_count % 40 == 0) send_pace = $urandom_range(2);
    pause = draw_pause(send_pace);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = predict_walk(req);
    expected_results.push_back(typed_want ? want : predicted);
    sent_count++;
    op_count[req.operation]++;
  endtask

  // Register writes go through a setup cycle and an access cycle.
  task automatic write_flag_mask(logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * CFG_ENTRY_FLAG_MASK);
    pwdata  <= {20'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    flag_mask = value;
    @(posedge clk);
  endtask

  task automatic check_flag_mask();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_AW'(4 * CFG_ENTRY_FLAG_MASK);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[11:0] !== flag_mask) begin
      note_mismatch("entry_flag_mask readback", $sformatf("%03h", flag_mask),
                    $sformatf("%03h", prdata[11:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: after each result taken, wait a drawn number of cycles with
  // ready low, then hold ready high until the next result goes through.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    out_ready = 1'b0;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) sink_pace = $urandom_range(2);
      stall = draw_pause(sink_pace);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Every result taken is held against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    tlpt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", "no result pending", show_result(out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status ||
            out_data.result_address !== want.result_address ||
            out_data.flush_one_page !== want.flush_one_page ||
            out_data.flush_everything !== want.flush_everything) begin
          note_mismatch("result", show_result(want), show_result(out_data));
        end
      end
    end
  end

  initial begin : stimulus
    logic [11:0] mask_plan [PHASES];
    tlpt_out_t   no_want;
    clk      = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    no_want  = '0;
    mismatch_count  = 0;
    results_checked = 0;
    sent_count      = 0;
    tables_created  = 0;
    op_count        = '{0, 0, 0, 0};
    send_pace       = 0;
    sink_pace       = 0;
    flag_mask       = FLAG_MASK_RESET;
    for (int i = 0; i < DIR_N; i++) dir_mirror[i] = '0;

    // Directed table. The first rows run on an empty directory right after
    // reset, so their results are plain to write down: missing tables,
    // misaligned addresses, a map without a free frame, the first map, and
    // a repeated map with and without a directory permission upgrade.
    add_case(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 32'h0, 1, ST_NO_TABLE);
    add_case(OP_UNMAP,     32'hFFFF_F000, 32'h0, 12'h000, 32'h0, 1, ST_NO_TABLE);
    add_case(OP_OR_FLAGS,  32'h0040_0000, 32'h0, 12'h006, 32'h0, 1, ST_NO_TABLE);
    add_case(OP_MAP,       32'h0000_0001, 32'h0, 12'h001, 32'h1000, 1, ST_MISALIGNED);
    add_case(OP_MAP,       32'h0000_0000, 32'h0000_0800, 12'h001, 32'h1000, 1, ST_MISALIGNED);
    add_case(OP_UNMAP,     32'h0000_0FFF, 32'h0, 12'h000, 32'h0, 1, ST_MISALIGNED);
    add_case(OP_OR_FLAGS,  32'h1234_5004, 32'h0, 12'h006, 32'h0, 1, ST_MISALIGNED);
    add_case(OP_MAP,       32'h0000_0000, 32'h0000_1000, 12'h007, 32'h0, 1, ST_NO_FRAME);
    // Table frame with stray low bits: only its frame part is kept.
    add_case(OP_MAP,       32'h0000_0000, 32'hFFFF_F000, 12'h001, 32'h1234_5FFF, 1,
             ST_OK, 32'h0, 1'b1, 1'b1);
    add_case(OP_MAP,       32'h0000_0000, 32'h0000_5000, 12'h001, 32'h0, 1, ST_ALREADY);
    add_case(OP_MAP,       32'h0000_0000, 32'h0000_5000, 12'h004, 32'h0, 1,
             ST_ALREADY, 32'h0, 1'b0, 1'b1);
    add_case(OP_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000, 32'h0, 1, ST_OK, 32'hFFFF_FFFF);
    // From here on the walker supplies the expectations.
    add_case(OP_OR_FLAGS,  32'h0000_1000, 32'h0, 12'h006, 32'h0);
    add_case(OP_MAP,       32'hFFFF_F000, 32'h0, 12'h000, 32'hFFFF_F000);
    add_case(OP_OR_FLAGS,  32'hFFFF_F000, 32'h0, 12'h006, 32'h0);
    add_case(OP_OR_FLAGS,  32'hFFFF_F000, 32'h0, 12'hFFF, 32'h0);
    add_case(OP_MAP,       32'h0040_0000, 32'h0000_2000, 12'h002, 32'h0000_3000);
    add_case(OP_OR_FLAGS,  32'h0040_1000, 32'h0, 12'h004, 32'h0);
    add_case(OP_TRANSLATE, 32'hFFFF_FABC, 32'h0, 12'h000, 32'h0);
    add_case(OP_UNMAP,     32'hFFFF_F000, 32'h0, 12'h000, 32'h0);
    add_case(OP_UNMAP,     32'hFFFF_F000, 32'h0, 12'h000, 32'h0);
    add_case(OP_TRANSLATE, 32'h0040_1234, 32'h0, 12'h000, 32'h0);
    add_case(OP_UNMAP,     32'h0000_0000, 32'h0, 12'h000, 32'h0);
    add_case(OP_MAP,       32'h0000_0000, 32'h8000_0000, 12'hFFF, 32'h0);
    add_case(OP_TRANSLATE, 32'h0000_0123, 32'h0, 12'h000, 32'h0);

    // Mask settings per phase: all bits, none, a random one, only the
    // permission bits, and another random one.
    mask_plan[0] = 12'hFFF;
    mask_plan[1] = 12'h000;
    mask_plan[2] = 12'($urandom_range(4095));
    mask_plan[3] = 12'h007;
    mask_plan[4] = 12'($urandom_range(4095));

    // Synchronous reset, released on an edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The engine clears its directory after reset and takes no item until
    // then; the sender simply waits for in_ready, so no delay is needed.
    for (int p = 0; p < PHASES; p++) begin
      write_flag_mask(mask_plan[p]);
      check_flag_mask();
      if (p == 0) begin
        foreach (directed_cases[i]) begin
          send_request(directed_cases[i].req, directed_cases[i].typed_want,
                       directed_cases[i].want);
        end
      end
      repeat (RANDOM_PER_PHASE) send_request(make_random_request(), 1'b0, no_want);
      in_valid <= 1'b0;
      // The mask may only change once the engine has drained.
      while (expected_results.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end

    // Leave room for any stray result after the last expected one.
    repeat (20) @(posedge clk);

    $display("Sent %0d requests (map %0d, unmap %0d, translate %0d, flag upgrade %0d)",
             sent_count, op_count[OP_MAP], op_count[OP_UNMAP], op_count[OP_TRANSLATE],
             op_count[OP_OR_FLAGS]);
    $display("over %0d flag mask settings; %0d page tables created, %0d results checked",
             PHASES, tables_created, results_checked);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
